>>> rtl/core/assert_macros.svh
// Assertion helpers for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Checked at each clock edge, ignored while reset is high.
`define ASSERT_CHECK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at each clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CHECK(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

>>> rtl/core/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

   localparam int OP_W    = 2;
   localparam int CHAR_W  = 8;
   localparam int SEL_W   = 2;
   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int INDEX_W = 11;
   localparam int ATTR_W  = 8;
   localparam int CELL_W  = CHAR_W + ATTR_W;
   localparam int REG_W   = 2;

   localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OP_W-1:0] OP_MOVE  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
   localparam logic [OP_W-1:0] OP_READ  = 2'd3;

   localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

   localparam logic [SEL_W-1:0] SEL_KERNEL  = 2'd1;
   localparam logic [SEL_W-1:0] SEL_PROGRAM = 2'd2;

   localparam logic [REG_W-1:0] REG_ATTR_NORMAL  = 2'd0;
   localparam logic [REG_W-1:0] REG_ATTR_KERNEL  = 2'd1;
   localparam logic [REG_W-1:0] REG_ATTR_PROGRAM = 2'd2;

   localparam logic [ATTR_W-1:0] ATTR_NORMAL_RST  = 8'd7;
   localparam logic [ATTR_W-1:0] ATTR_KERNEL_RST  = 8'd4;
   localparam logic [ATTR_W-1:0] ATTR_PROGRAM_RST = 8'd2;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [CHAR_W-1:0] char_code;
      logic [SEL_W-1:0]  attr_select;
      logic [COL_W-1:0]  target_col;
      logic [ROW_W-1:0]  target_row;
   } req_payload_type;

   typedef struct packed {
      logic [COL_W-1:0]   cursor_col;
      logic [ROW_W-1:0]   cursor_row;
      logic [INDEX_W-1:0] cursor_index;
      logic [CHAR_W-1:0]  cell_char;
      logic [ATTR_W-1:0]  cell_attr;
   } rsp_payload_type;

   typedef struct packed {
      logic [REG_W-1:0]  reg_index;
      logic [ATTR_W-1:0] reg_data;
   } csr_payload_type;

endpackage

>>> rtl/core/tcw_chan_if.sv
`timescale 1ns / 1ps

interface tcw_req_if;
   logic                     valid;
   logic                     ready;
   tcw_pkg::req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface tcw_rsp_if;
   logic                     valid;
   logic                     ready;
   tcw_pkg::rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface tcw_csr_if;
   logic                     valid;
   logic                     ready;
   tcw_pkg::csr_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/tcw_ram.sv
`timescale 1ns / 1ps

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/text_console_char_writer.sv
`timescale 1ns / 1ps
// Channel    Role    Payload
// req_chan   sink    op, char_code, attr_select, target_col, target_row
// rsp_chan   source  cursor_col, cursor_row, cursor_index, cell_char, cell_attr
// csr_chan   sink    reg_index, reg_data (always ready)
//
// Put, move and read go through accept, then the result stage where the
// screen RAM read data and the updated cursor land in the output register.
// Clear and a scrolling put add a sweep of the screen RAM, one cell a cycle,
// over every cell of the screen before the next accept.
// After reset the same sweep zeroes the RAM before the first item is taken.
// A stalled result blocks the next accept only while the output register is full.

`include "assert_macros.svh"

module text_console_char_writer #(
   parameter int SCREEN_COLS = 80,
   parameter int LAST_ROW    = 24,
   parameter int TAB_WIDTH   = 8
) (
   input logic        clock,
   input logic        reset,
   tcw_req_if.sink    req_chan,
   tcw_rsp_if.source  rsp_chan,
   tcw_csr_if.sink    csr_chan
);

   import tcw_pkg::*;

   localparam int NUM_CELLS  = SCREEN_COLS * (LAST_ROW + 1);
   localparam int COPY_CELLS = SCREEN_COLS * LAST_ROW;
   localparam int AW         = $clog2(NUM_CELLS);
   localparam int CW         = $clog2(SCREEN_COLS);
   localparam int RW         = (LAST_ROW > 1) ? $clog2(LAST_ROW + 1) : 1;
   localparam int CTW        = $clog2(SCREEN_COLS + TAB_WIDTH + 1);
   localparam int TAB_STOPS  = SCREEN_COLS / TAB_WIDTH + 1;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_POST  = 2'd1;
   localparam logic [1:0] S_SWEEP = 2'd2;
   localparam logic [1:0] S_DRAIN = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [CW-1:0]     cur_col_ff, cur_col_in;
   logic [RW-1:0]     cur_row_ff, cur_row_in;
   logic [ATTR_W-1:0] attr_normal_ff, attr_kernel_ff, attr_program_ff;
   logic              is_read_ff, is_read_in;
   logic              sweep_pend_ff, sweep_pend_in;
   logic              scroll_ff, scroll_in;
   logic [CELL_W-1:0] fill_ff, fill_in;
   logic [AW-1:0]     sweep_idx_ff, sweep_idx_in;
   logic              wp_vld_ff, wp_copy_ff;
   logic [AW-1:0]     wp_addr_ff;
   logic              rsp_vld_ff, rsp_vld_in;
   rsp_payload_type   rsp_data_ff;

   req_payload_type   req;
   logic              acc;
   logic [ATTR_W-1:0] attr;
   logic [AW-1:0]     base;
   logic [CTW-1:0]    tab_col, col_x;
   logic              put_we, wrap, sweep_copy;
   logic [AW-1:0]     put_addr;
   logic [CELL_W-1:0] put_data;
   logic [CW-1:0]     clamp_col;
   logic [RW-1:0]     clamp_row;
   logic [AW-1:0]     read_addr;
   logic              ram_we;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [CELL_W-1:0] ram_wdata, ram_rdata;

   assign req            = req_chan.payload;
   assign req_chan.ready = (state_ff == S_IDLE) && (!rsp_vld_ff || rsp_chan.ready);
   assign acc            = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         attr_normal_ff  <= ATTR_NORMAL_RST;
         attr_kernel_ff  <= ATTR_KERNEL_RST;
         attr_program_ff <= ATTR_PROGRAM_RST;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.payload.reg_index)
            REG_ATTR_NORMAL:  attr_normal_ff  <= csr_chan.payload.reg_data;
            REG_ATTR_KERNEL:  attr_kernel_ff  <= csr_chan.payload.reg_data;
            REG_ATTR_PROGRAM: attr_program_ff <= csr_chan.payload.reg_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (req.attr_select)
         SEL_KERNEL:  attr = attr_kernel_ff;
         SEL_PROGRAM: attr = attr_program_ff;
         default:     attr = attr_normal_ff;
      endcase
   end

   // ---------------- character placement ----------------
   assign base = AW'(cur_row_ff) * AW'(SCREEN_COLS) + AW'(cur_col_ff);

   // next tab stop strictly right of the cursor
   always_comb begin
      tab_col = CTW'(TAB_STOPS * TAB_WIDTH);
      for (int k = TAB_STOPS; k >= 1; k--) begin
         if (CTW'(k * TAB_WIDTH) > CTW'(cur_col_ff)) begin
            tab_col = CTW'(k * TAB_WIDTH);
         end
      end
   end

   always_comb begin
      put_we   = 1'b0;
      put_addr = base;
      put_data = {attr, req.char_code};
      unique case (req.char_code)
         CH_TAB: col_x = tab_col;
         CH_CR:  col_x = '0;
         CH_LF:  col_x = CTW'(cur_col_ff);
         CH_BS: begin
            if (cur_col_ff != '0) begin
               col_x    = CTW'(cur_col_ff) - CTW'(1);
               put_we   = 1'b1;
               put_addr = base - AW'(1);
               put_data = {attr, CH_SPACE};
            end else begin
               col_x = '0;
            end
         end
         default: begin
            col_x  = CTW'(cur_col_ff) + CTW'(1);
            put_we = 1'b1;
         end
      endcase
      put_we = put_we && acc && (req.op == OP_PUT);
   end

   assign wrap = (col_x >= CTW'(SCREEN_COLS)) || (req.char_code == CH_LF);

   assign clamp_col = (req.target_col > 7'(SCREEN_COLS - 1)) ? CW'(SCREEN_COLS - 1)
                                                            : CW'(req.target_col);
   assign clamp_row = (6'(req.target_row) > 6'(LAST_ROW)) ? RW'(LAST_ROW)
                                                          : RW'(req.target_row);
   assign read_addr = AW'(clamp_row) * AW'(SCREEN_COLS) + AW'(clamp_col);

   // ---------------- control ----------------
   assign sweep_copy = scroll_ff && (sweep_idx_ff < AW'(COPY_CELLS));

   always_comb begin
      state_in      = state_ff;
      cur_col_in    = cur_col_ff;
      cur_row_in    = cur_row_ff;
      is_read_in    = is_read_ff;
      sweep_pend_in = sweep_pend_ff;
      scroll_in     = scroll_ff;
      fill_in       = fill_ff;
      sweep_idx_in  = sweep_idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (acc) begin
               state_in      = S_POST;
               is_read_in    = (req.op == OP_READ);
               sweep_pend_in = 1'b0;
               sweep_idx_in  = '0;
               unique case (req.op)
                  OP_PUT: begin
                     if (wrap) begin
                        cur_col_in = '0;
                        if (cur_row_ff < RW'(LAST_ROW)) begin
                           cur_row_in = cur_row_ff + RW'(1);
                        end else begin
                           sweep_pend_in = 1'b1;
                           scroll_in     = 1'b1;
                           fill_in       = {attr, CH_SPACE};
                        end
                     end else begin
                        cur_col_in = col_x[CW-1:0];
                     end
                  end
                  OP_MOVE: begin
                     cur_col_in = clamp_col;
                     cur_row_in = clamp_row;
                  end
                  OP_CLEAR: begin
                     cur_col_in    = '0;
                     cur_row_in    = '0;
                     sweep_pend_in = 1'b1;
                     scroll_in     = 1'b0;
                     fill_in       = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_POST: begin
            state_in = sweep_pend_ff ? S_SWEEP : S_IDLE;
         end
         S_SWEEP: begin
            if (sweep_idx_ff == AW'(NUM_CELLS - 1)) begin
               state_in = S_DRAIN;
            end else begin
               sweep_idx_in = sweep_idx_ff + AW'(1);
            end
         end
         S_DRAIN: begin
            state_in      = S_IDLE;
            sweep_pend_in = 1'b0;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_SWEEP;
         cur_col_ff    <= '0;
         cur_row_ff    <= '0;
         is_read_ff    <= 1'b0;
         sweep_pend_ff <= 1'b0;
         scroll_ff     <= 1'b0;
         fill_ff       <= '0;
         sweep_idx_ff  <= '0;
         wp_vld_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_col_ff    <= cur_col_in;
         cur_row_ff    <= cur_row_in;
         is_read_ff    <= is_read_in;
         sweep_pend_ff <= sweep_pend_in;
         scroll_ff     <= scroll_in;
         fill_ff       <= fill_in;
         sweep_idx_ff  <= sweep_idx_in;
         wp_vld_ff     <= (state_ff == S_SWEEP);
      end
   end

   // sweep write stage trails its read: it writes in the cycle after the read
   always_ff @(posedge clock) begin
      wp_addr_ff <= sweep_idx_ff;
      wp_copy_ff <= sweep_copy;
   end

   // ---------------- screen RAM ----------------
   assign ram_we    = put_we || wp_vld_ff;
   assign ram_waddr = put_we ? put_addr : wp_addr_ff;
   assign ram_wdata = put_we ? put_data : (wp_copy_ff ? ram_rdata : fill_ff);
   assign ram_raddr = (state_ff == S_IDLE) ? read_addr
                    : (sweep_copy ? sweep_idx_ff + AW'(SCREEN_COLS) : sweep_idx_ff);

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (NUM_CELLS)
   ) u_screen (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // ---------------- result register ----------------
   always_comb begin
      if (state_ff == S_POST) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_POST) begin
         rsp_data_ff.cursor_col   <= COL_W'(cur_col_ff);
         rsp_data_ff.cursor_row   <= ROW_W'(cur_row_ff);
         rsp_data_ff.cursor_index <= INDEX_W'(base);
         rsp_data_ff.cell_char    <= is_read_ff ? ram_rdata[CHAR_W-1:0] : '0;
         rsp_data_ff.cell_attr    <= is_read_ff ? ram_rdata[CELL_W-1:CHAR_W] : '0;
      end
   end

   assign rsp_chan.valid   = rsp_vld_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // ---------------- checks ----------------
   `ASSERT_CHECK(a_accept_then_post, clock, reset, (acc |=> state_ff == S_POST), "accepted item did not reach the result stage")
   `ASSERT_CHECK(a_rsp_from_post, clock, reset, ($rose(rsp_vld_ff) |-> $past(state_ff) == S_POST), "result raised outside the result stage")
   `ASSERT_CHECK(a_one_writer, clock, reset, (!(put_we && wp_vld_ff)), "character write collided with sweep write")
   `ASSERT_CHECK(a_cursor_range, clock, reset, (cur_col_ff < CW'(SCREEN_COLS) && cur_row_ff <= RW'(LAST_ROW)), "cursor left the screen")
   `ASSERT_CHECK(a_no_slot_overrun, clock, reset, (state_ff == S_POST |-> !rsp_vld_ff), "result stage found the output register full")

endmodule
